[rtl/p25_frame_sync_detector_assert.svh]
// Assertion macros shared by the frame sync detector RTL.
// Depends on nothing; included by p25_frame_sync_detector, the only module that carries assertions.
`ifndef P25_FRAME_SYNC_DETECTOR_ASSERT_SVH
`define P25_FRAME_SYNC_DETECTOR_ASSERT_SVH

// Antecedent and consequent checked in the same cycle.
`define P25FSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define P25FSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/p25fsd_pkg.sv]
// Shared constants and types of the P25 frame sync detector.
// No dependencies; imported by p25fsd_rank and p25_frame_sync_detector.
package p25fsd_pkg;

   localparam int WINDOW     = 24;
   localparam int SYM_W      = 16;
   localparam int SUM_W      = 18;
   localparam int ABS_W      = 17;
   localparam int PTR_W      = 5;
   localparam int CNT_W      = 11;
   localparam int RUN_W      = 8;
   localparam int ERR_W      = 5;
   localparam int RANK_DEPTH = 5;
   localparam int LEVEL_START = 18;

   // Division of a 17-bit magnitude by 3: multiply by ceil(2^17/3), keep the top bits.
   localparam int DIV3_SHIFT = 17;
   localparam logic [15:0] DIV3_RECIP = 16'd43691;

   // Bit i is set where symbol i (oldest first) of the sync word is an outer '1'.
   localparam logic [WINDOW-1:0] SYNC_ONES = 24'b0000_0101_0000_1100_1101_1111;

   localparam logic signed [SYM_W-1:0] SYM_MAX = 16'sh7FFF;
   localparam logic signed [SYM_W-1:0] SYM_MIN = 16'sh8000;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_MAX_ERRORS    = 3'd0;
   localparam logic [2:0] CSR_SYNC_ENABLE   = 3'd1;
   localparam logic [2:0] CSR_HUNT_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_ACQUIRE_AFTER = 3'd3;
   localparam logic [2:0] CSR_LOCK_RUN      = 3'd4;

   // Result status codes.
   localparam logic [1:0] STATUS_SEARCH  = 2'd0;
   localparam logic [1:0] STATUS_SYNC    = 2'd1;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

   typedef struct packed {
      logic clear;
      logic insert;
   } rank_ctl_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] low_sum;
      logic signed [SUM_W-1:0] high_sum;
   } rank_sums_type;

endpackage

[rtl/p25fsd_rank.sv]
// Rank tracker: keeps the five smallest and five largest samples of a scan.
// Depends on p25fsd_pkg; gives the sums of the 3rd to 5th of each list.
module p25fsd_rank import p25fsd_pkg::*; (
   input  logic                    clock,
   input  rank_ctl_type            ctl,
   input  logic signed [SYM_W-1:0] sample,
   output rank_sums_type           sums
);

   logic signed [SYM_W-1:0] low_ff  [RANK_DEPTH];
   logic signed [SYM_W-1:0] low_in  [RANK_DEPTH];
   logic signed [SYM_W-1:0] high_ff [RANK_DEPTH];
   logic signed [SYM_W-1:0] high_in [RANK_DEPTH];
   logic [RANK_DEPTH-1:0]   lt;
   logic [RANK_DEPTH-1:0]   gt;

   // Both lists are kept sorted, the low one ascending and the high one
   // descending, so a new word shifts the tail of each list down one slot.
   always_comb begin
      for (int i = 0; i < RANK_DEPTH; i++) begin
         lt[i] = sample < low_ff[i];
         gt[i] = sample > high_ff[i];
      end
      for (int i = 0; i < RANK_DEPTH; i++) begin
         low_in[i]  = low_ff[i];
         high_in[i] = high_ff[i];
      end
      if (ctl.clear) begin
         for (int i = 0; i < RANK_DEPTH; i++) begin
            low_in[i]  = SYM_MAX;
            high_in[i] = SYM_MIN;
         end
      end else if (ctl.insert) begin
         if (lt[0]) begin
            low_in[0] = sample;
         end
         if (gt[0]) begin
            high_in[0] = sample;
         end
         for (int i = 1; i < RANK_DEPTH; i++) begin
            if (lt[i]) begin
               low_in[i] = lt[i-1] ? low_ff[i-1] : sample;
            end
            if (gt[i]) begin
               high_in[i] = gt[i-1] ? high_ff[i-1] : sample;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RANK_DEPTH; i++) begin
         low_ff[i]  <= low_in[i];
         high_ff[i] <= high_in[i];
      end
   end

   assign sums.low_sum  = SUM_W'(low_ff[2]) + SUM_W'(low_ff[3]) + SUM_W'(low_ff[4]);
   assign sums.high_sum = SUM_W'(high_ff[2]) + SUM_W'(high_ff[3]) + SUM_W'(high_ff[4]);

endmodule

[rtl/p25_frame_sync_detector.sv]
// P25 frame sync detector: symbol window memory, level estimate, sync correlation.
// First 17 symbols of a hunt go straight to the result; later ones scan the window
// for the levels (then sum, multiply, sign, mid) and, from the 24th symbol with the
// search on, scan it again to compare. One word at a time; the scans take longest.
// Reset (synchronous, active high) restores register defaults and starts an empty hunt.
// Depends on p25fsd_pkg, p25fsd_rank and p25_frame_sync_detector_assert.svh.
`include "p25_frame_sync_detector_assert.svh"

module p25_frame_sync_detector import p25fsd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [SYM_W-1:0] req_symbol,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [CNT_W-1:0]        rsp_position,
   output logic [ERR_W-1:0]        rsp_errors_normal,
   output logic [ERR_W-1:0]        rsp_errors_inverted,
   output logic                    rsp_inverted_match,
   output logic signed [SYM_W-1:0] rsp_level_low,
   output logic signed [SYM_W-1:0] rsp_level_high,
   output logic                    rsp_acquiring,
   input  logic                    csr_write_enable,
   input  logic [2:0]              csr_index,
   input  logic [CNT_W-1:0]        csr_write_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_SUM  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_SIGN = 3'd4;
   localparam logic [2:0] ST_MID  = 3'd5;
   localparam logic [2:0] ST_CMP  = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   // Configuration registers.
   logic [ERR_W-1:0] max_errors_ff;
   logic             sync_enable_ff;
   logic [CNT_W-1:0] hunt_limit_ff;
   logic [CNT_W-1:0] acquire_after_ff;
   logic [RUN_W-1:0] lock_run_ff;

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic [PTR_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  hunt_ff, hunt_in;
   logic [RUN_W-1:0]  run_ff, run_in;
   logic [WINDOW-1:0] valid_ff, valid_in;
   logic [PTR_W-1:0]  addr_ff, addr_in;
   logic [PTR_W-1:0]  step_ff, step_in;
   logic [PTR_W-1:0]  proc_ff, proc_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              cmp_ff, cmp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [SYM_W-1:0] win_mem [WINDOW];
   logic signed [SYM_W-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [ABS_W-1:0]        abs_lo_ff, abs_lo_in, abs_hi_ff, abs_hi_in;
   logic                    neg_lo_ff, neg_lo_in, neg_hi_ff, neg_hi_in;
   logic [SYM_W-1:0]        q_lo_ff, q_lo_in, q_hi_ff, q_hi_in;
   logic signed [SYM_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [ERR_W-1:0]        en_ff, en_in;

   logic [1:0]              rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_position_ff, rsp_position_in;
   logic [ERR_W-1:0]        rsp_en_ff, rsp_en_in, rsp_ei_ff, rsp_ei_in;
   logic                    rsp_inv_ff, rsp_inv_in, rsp_acq_ff, rsp_acq_in;
   logic signed [SYM_W-1:0] rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;

   logic                    accept;
   logic                    mem_we;
   logic signed [SYM_W-1:0] rd_sample;
   rank_ctl_type            rank_ctl;
   rank_sums_type           rank_sums;
   logic [CNT_W:0]          hunt_next;
   logic [ERR_W-1:0]        ei;
   logic                    is_sync, is_inv, is_timeout, acq;
   logic [ABS_W+15:0]       prod_lo, prod_hi;
   logic signed [SYM_W:0]   mid_sum, mid_adj;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign mem_we    = accept;
   assign rd_sample = rd_valid_ff ? rd_data_ff : '0;

   assign rank_ctl.clear  = accept;
   assign rank_ctl.insert = (state_ff == ST_SCAN) && rd_pend_ff;

   p25fsd_rank u_rank (
      .clock  (clock),
      .ctl    (rank_ctl),
      .sample (rd_sample),
      .sums   (rank_sums)
   );

   // The window word is written only on accept, while no scan runs, so no read
   // that a scan uses meets a write to the same slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[ptr_ff] <= req_symbol;
      end
      rd_data_ff  <= win_mem[addr_ff];
      rd_valid_ff <= valid_ff[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_errors_ff    <= ERR_W'(3);
         sync_enable_ff   <= 1'b1;
         hunt_limit_ff    <= CNT_W'(1800);
         acquire_after_ff <= CNT_W'(30);
         lock_run_ff      <= RUN_W'(2);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_ERRORS:    max_errors_ff    <= csr_write_data[ERR_W-1:0];
            CSR_SYNC_ENABLE:   sync_enable_ff   <= csr_write_data[0];
            CSR_HUNT_LIMIT:    hunt_limit_ff    <= csr_write_data;
            CSR_ACQUIRE_AFTER: acquire_after_ff <= csr_write_data;
            CSR_LOCK_RUN:      lock_run_ff      <= csr_write_data[RUN_W-1:0];
            default: ;
         endcase
      end
   end

   // Result of the finished word.
   assign hunt_next  = {1'b0, hunt_ff} + 1'b1;
   assign ei         = ERR_W'(WINDOW) - en_ff;
   assign is_sync    = cmp_ff && (en_ff <= max_errors_ff);
   assign is_inv     = cmp_ff && !is_sync && (ei <= max_errors_ff);
   assign is_timeout = !is_sync && (hunt_next >= {1'b0, hunt_limit_ff});
   assign acq        = (hunt_next > {1'b0, acquire_after_ff}) || (run_ff < lock_run_ff);

   assign prod_lo = abs_lo_ff * DIV3_RECIP;
   assign prod_hi = abs_hi_ff * DIV3_RECIP;
   assign mid_sum = (SYM_W+1)'(lo_ff) + (SYM_W+1)'(hi_ff);
   // Adding one to a negative sum makes the arithmetic shift round toward zero.
   assign mid_adj = mid_sum + (SYM_W+1)'(mid_sum[SYM_W]);

   always_comb begin
      state_in        = state_ff;
      ptr_in          = ptr_ff;
      hunt_in         = hunt_ff;
      run_in          = run_ff;
      valid_in        = valid_ff;
      addr_in         = addr_ff;
      step_in         = step_ff;
      proc_in         = proc_ff;
      rd_pend_in      = 1'b0;
      cmp_in          = cmp_ff;
      abs_lo_in       = abs_lo_ff;
      abs_hi_in       = abs_hi_ff;
      neg_lo_in       = neg_lo_ff;
      neg_hi_in       = neg_hi_ff;
      q_lo_in         = q_lo_ff;
      q_hi_in         = q_hi_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      en_in           = en_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      rsp_en_in       = rsp_en_ff;
      rsp_ei_in       = rsp_ei_ff;
      rsp_inv_in      = rsp_inv_ff;
      rsp_acq_in      = rsp_acq_ff;
      rsp_lo_in       = rsp_lo_ff;
      rsp_hi_in       = rsp_hi_ff;

      // A scan issues one read a cycle; data is used the cycle after.
      if ((state_ff == ST_SCAN || state_ff == ST_CMP) && step_ff < PTR_W'(WINDOW)) begin
         rd_pend_in = 1'b1;
         step_in    = step_ff + 1'b1;
         addr_in    = (addr_ff == PTR_W'(WINDOW - 1)) ? '0 : addr_ff + 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               valid_in[ptr_ff] = 1'b1;
               ptr_in  = (ptr_ff == PTR_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
               // Starting at the next write slot (the oldest word once the window is full),
               // a full scan ends where it began, ready for the in-order compare pass.
               addr_in = ptr_in;
               step_in = '0;
               cmp_in  = 1'b0;
               lo_in   = '0;
               hi_in   = '0;
               en_in   = ERR_W'(WINDOW);
               state_in = (hunt_ff >= CNT_W'(LEVEL_START - 1)) ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (step_ff == PTR_W'(WINDOW)) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            neg_lo_in = rank_sums.low_sum[SUM_W-1];
            neg_hi_in = rank_sums.high_sum[SUM_W-1];
            abs_lo_in = ABS_W'(neg_lo_in ? -rank_sums.low_sum : rank_sums.low_sum);
            abs_hi_in = ABS_W'(neg_hi_in ? -rank_sums.high_sum : rank_sums.high_sum);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            q_lo_in  = prod_lo[DIV3_SHIFT +: SYM_W];
            q_hi_in  = prod_hi[DIV3_SHIFT +: SYM_W];
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            lo_in    = neg_lo_ff ? -q_lo_ff : q_lo_ff;
            hi_in    = neg_hi_ff ? -q_hi_ff : q_hi_ff;
            state_in = ST_MID;
         end
         ST_MID: begin
            mid_in = mid_adj[SYM_W:1];
            if (sync_enable_ff && hunt_ff >= CNT_W'(WINDOW - 1)) begin
               step_in  = '0;
               proc_in  = '0;
               en_in    = '0;
               cmp_in   = 1'b1;
               state_in = ST_CMP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CMP: begin
            if (rd_pend_ff) begin
               proc_in = proc_ff + 1'b1;
               if ((rd_sample > mid_ff) != SYNC_ONES[proc_ff]) begin
                  en_in = en_ff + 1'b1;
               end
            end
            if (step_ff == PTR_W'(WINDOW)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = is_sync ? STATUS_SYNC :
                                 (is_timeout ? STATUS_TIMEOUT : STATUS_SEARCH);
               rsp_position_in = hunt_ff;
               rsp_en_in       = en_ff;
               // Without a compare pass both error counts read as a full window.
               rsp_ei_in       = cmp_ff ? ei : ERR_W'(WINDOW);
               rsp_inv_in      = is_inv;
               rsp_acq_in      = acq;
               rsp_lo_in       = lo_ff;
               rsp_hi_in       = hi_ff;
               if (is_sync) begin
                  if (hunt_next <= {1'b0, acquire_after_ff}) begin
                     run_in = (run_ff == '1) ? run_ff : run_ff + 1'b1;
                  end else begin
                     run_in = RUN_W'(1);
                  end
               end
               if (is_sync || is_timeout) begin
                  hunt_in  = '0;
                  ptr_in   = '0;
                  valid_in = '0;
               end else begin
                  hunt_in = hunt_next[CNT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         hunt_ff      <= '0;
         run_ff       <= '0;
         valid_ff     <= '0;
         addr_ff      <= '0;
         step_ff      <= '0;
         proc_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         hunt_ff      <= hunt_in;
         run_ff       <= run_in;
         valid_ff     <= valid_in;
         addr_ff      <= addr_in;
         step_ff      <= step_in;
         proc_ff      <= proc_in;
         rd_pend_ff   <= rd_pend_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_lo_ff       <= abs_lo_in;
      abs_hi_ff       <= abs_hi_in;
      neg_lo_ff       <= neg_lo_in;
      neg_hi_ff       <= neg_hi_in;
      q_lo_ff         <= q_lo_in;
      q_hi_ff         <= q_hi_in;
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      en_ff           <= en_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
      rsp_en_ff       <= rsp_en_in;
      rsp_ei_ff       <= rsp_ei_in;
      rsp_inv_ff      <= rsp_inv_in;
      rsp_acq_ff      <= rsp_acq_in;
      rsp_lo_ff       <= rsp_lo_in;
      rsp_hi_ff       <= rsp_hi_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_position        = rsp_position_ff;
   assign rsp_errors_normal   = rsp_en_ff;
   assign rsp_errors_inverted = rsp_ei_ff;
   assign rsp_inverted_match  = rsp_inv_ff;
   assign rsp_level_low       = rsp_lo_ff;
   assign rsp_level_high      = rsp_hi_ff;
   assign rsp_acquiring       = rsp_acq_ff;

   `P25FSD_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, state_ff != ST_IDLE, "word accepted but block still idle")
   `P25FSD_ASSERT_NOW(a_new_hunt_clean, clock, reset, state_ff == ST_IDLE && hunt_ff == '0, ptr_ff == '0 && valid_ff == '0, "new hunt with stale window state")
   `P25FSD_ASSERT_NOW(a_cmp_window_full, clock, reset, state_ff == ST_CMP, valid_ff == '1, "compare pass over a window that is not full")
   `P25FSD_ASSERT_NOW(a_sync_not_inverted, clock, reset, rsp_valid_ff && rsp_status_ff == STATUS_SYNC, !rsp_inv_ff, "sync result also flagged as inverted")

endmodule
